/* hw/rtl/min_priority_queue_top_assert.svh */
// ----------------------------------------------------------------------------
// min_priority_queue_top assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MPQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mpq assertion failed");

// next-cycle implication
`define MPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mpq assertion failed");

`else

`define MPQ_ASSERT_NOW(label, ante, cons)
`define MPQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hw/rtl/mpq_pkg.sv */
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and codes of the minimum priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

   localparam int VALUE_W = 32;

   // operation codes carried in req_tuser
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_PEEK   = 2'd2;

   // status codes carried in rsp_tuser
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

   // contents of one cell
   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
   } slot_type;

   // command broadcast to every cell
   typedef struct packed {
      logic                      ins;
      logic                      del;
      logic signed [VALUE_W-1:0] value;
   } cmd_type;

endpackage

/* hw/rtl/min_priority_queue_top.sv */
// ----------------------------------------------------------------------------
// min_priority_queue_top
// Bounded minimum priority queue of signed 32-bit words on a sorted cell chain.
// ----------------------------------------------------------------------------
// Input channel req_*: tuser carries the operation (insert, delete smallest,
// peek smallest), tdata the value to insert. Result channel rsp_*: tdata is
// the smallest value removed or peeked (-1 when empty, 0 for insert), tuser
// the status (ok, empty, full).
// Every operation gives exactly one result word, registered in the cycle
// after the request is taken. One operation is taken per cycle while the
// receiver does not stall: all DEPTH cells compare the incoming value in
// parallel and shift by one place in the same cycle, so the chain is always
// sorted and the smallest value sits in the head cell. The 32-bit signed
// compare broadcast to every cell sets the cycle time.
// Reset clears the valid bit of every cell, leaving the queue empty; stored
// values need no clearing. When the receiver stalls, the result word holds
// in the output register and req_tready stays low until it is taken; a new
// request is taken in the same cycle that the old result leaves.
// ----------------------------------------------------------------------------
module min_priority_queue_top #(
   parameter int DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] value
   input  logic [1:0]  req_tuser,  // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [31:0] result_value
   output logic [1:0]  rsp_tuser   // [1:0] status
);
   import mpq_pkg::*;

   slot_type   slot       [DEPTH];
   slot_type   left_slot  [DEPTH];
   slot_type   right_slot [DEPTH];
   logic       gt         [DEPTH];
   logic       left_gt    [DEPTH];
   logic [DEPTH-1:0] valid_vec;
   logic [DEPTH:0]   valid_plus;

   cmd_type     cmd;
   logic        fire;
   logic        full;
   logic        empty;

   logic        rsp_tvalid_ff;
   logic        rsp_tvalid_in;
   logic [31:0] rsp_data_ff;
   logic [31:0] rsp_data_in;
   logic [1:0]  rsp_user_ff;
   logic [1:0]  rsp_user_in;

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;
   assign empty      = !slot[0].valid;
   assign full       = slot[DEPTH-1].valid;

   assign cmd.ins   = fire && (req_tuser == OP_INSERT) && !full;
   assign cmd.del   = fire && (req_tuser == OP_DELETE) && !empty;
   assign cmd.value = $signed(req_tdata);

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         if (i == 0) begin : g_head
            assign left_slot[i] = '{valid: 1'b0, value: '0};
            assign left_gt[i]   = 1'b0;
         end else begin : g_mid
            assign left_slot[i] = slot[i-1];
            assign left_gt[i]   = gt[i-1];
         end
         if (i == DEPTH-1) begin : g_tail
            assign right_slot[i] = '{valid: 1'b0, value: '0};
         end else begin : g_body
            assign right_slot[i] = slot[i+1];
         end

         mpq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .left_slot  (left_slot[i]),
            .left_gt    (left_gt[i]),
            .right_slot (right_slot[i]),
            .slot       (slot[i]),
            .gt         (gt[i])
         );

         assign valid_vec[i] = slot[i].valid;
      end
   endgenerate

   assign valid_plus = {1'b0, valid_vec} + {{DEPTH{1'b0}}, 1'b1};

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      if (fire) begin
         rsp_tvalid_in = 1'b1;
         rsp_data_in   = '0;
         rsp_user_in   = ST_OK;
         case (req_tuser)
            OP_INSERT: begin
               if (full) begin
                  rsp_user_in = ST_FULL;
               end
            end
            OP_DELETE, OP_PEEK: begin
               if (empty) begin
                  rsp_data_in = EMPTY_VALUE;
                  rsp_user_in = ST_EMPTY;
               end else begin
                  rsp_data_in = slot[0].value;
               end
            end
            default: begin
               rsp_user_in = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`include "min_priority_queue_top_assert.svh"

   // occupied cells always form a prefix of the chain
   `MPQ_ASSERT_NOW(a_valid_prefix, 1'b1, $onehot0(valid_plus))
   // the two head cells stay in order
   `MPQ_ASSERT_NOW(a_head_sorted, slot[1].valid, $signed(slot[0].value) <= $signed(slot[1].value))
   // an accepted insert leaves the queue non-empty
   `MPQ_ASSERT_NEXT(a_insert_fills, cmd.ins, slot[0].valid)
   // an empty status always carries the empty marker
   `MPQ_ASSERT_NOW(a_empty_word, rsp_tvalid && (rsp_tuser == ST_EMPTY), rsp_tdata == EMPTY_VALUE)

endmodule

/* hw/rtl/mpq_cell.sv */
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain; shifts toward the tail on insert, toward the
// head on delete.
// ----------------------------------------------------------------------------
module mpq_cell (
   input  logic              clock,
   input  logic              reset,
   input  mpq_pkg::cmd_type  cmd,
   input  mpq_pkg::slot_type left_slot,
   input  logic              left_gt,
   input  mpq_pkg::slot_type right_slot,
   output mpq_pkg::slot_type slot,
   output logic              gt
);
   import mpq_pkg::*;

   logic                      valid_ff;
   logic                      valid_in;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   // new word belongs at or ahead of this slot; strict so equal keys keep order
   assign gt = !valid_ff || ($signed(cmd.value) < $signed(value_ff));

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (cmd.ins && gt) begin
         if (left_gt) begin
            valid_in = left_slot.valid;
            value_in = left_slot.value;
         end else begin
            valid_in = 1'b1;
            value_in = cmd.value;
         end
      end else if (cmd.del) begin
         valid_in = right_slot.valid;
         value_in = right_slot.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign slot = '{valid: valid_ff, value: value_ff};

endmodule
